@@ design/layout_ruler_stack_defines.svh @@
// Assertion macros shared by the layout ruler stack RTL.
`ifndef LAYOUT_RULER_STACK_DEFINES_SVH
`define LAYOUT_RULER_STACK_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define LRS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("layout_ruler_stack: check failed");

// Check that a condition implies another in the next cycle.
`define LRS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("layout_ruler_stack: check failed");

`endif

@@ design/lrs_pkg.sv @@
// Types and constants shared by the layout ruler stack modules.
`default_nettype none

package lrs_pkg;

    localparam int COL_W   = 16;
    localparam int DEPTH_W = 8;
    localparam int TOK_W   = 2;

    localparam logic [TOK_W-1:0] TOK_NONE      = 2'd0;
    localparam logic [TOK_W-1:0] TOK_BEGIN     = 2'd1;
    localparam logic [TOK_W-1:0] TOK_SEPARATOR = 2'd2;
    localparam logic [TOK_W-1:0] TOK_END       = 2'd3;

    // One token-scan request
    typedef struct packed {
        logic             recovering;
        logic             begin_allowed;
        logic             separator_allowed;
        logic             end_allowed;
        logic             after_newline;
        logic [COL_W-1:0] column;
        logic             stop_token;
    } t_req;

    // One layout result
    typedef struct packed {
        logic [TOK_W-1:0]   token;
        logic [DEPTH_W-1:0] depth;
    } t_rsp;

    // One ruler entry: tentative flag and column
    typedef struct packed {
        logic             pending;
        logic [COL_W-1:0] column;
    } t_ruler;

    // Sequencer status toward the output stage
    typedef struct packed {
        logic             done;
        logic [TOK_W-1:0] token;
    } t_ctl_sts;

endpackage

`default_nettype wire

@@ design/lrs_ruler_mem.sv @@
// Ruler stack memory: one write port, one read port with registered data.
`default_nettype none

module lrs_ruler_mem import lrs_pkg::*; #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire t_ruler            i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output t_ruler                 o_rd_data
);

    t_ruler r_mem [DEPTH];
    t_ruler r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry, data valid next cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ design/lrs_ctrl.sv @@
// Sequencer: stack top, begin search down the rulers, column compare unit.
`default_nettype none

module lrs_ctrl import lrs_pkg::*; #(
    parameter int MAX_TOP = 255,
    parameter int ADDR_W  = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire t_req              i_in_data,
    output logic                   o_in_ready,
    input  wire logic              i_take,
    output t_ctl_sts               o_sts,
    output logic [ADDR_W-1:0]      o_top,
    output logic                   o_wr_en,
    output logic [ADDR_W-1:0]      o_wr_addr,
    output t_ruler                 o_wr_data,
    output logic                   o_rd_en,
    output logic [ADDR_W-1:0]      o_rd_addr,
    input  wire t_ruler            i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXAM = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    t_req                r_req,   n_req;
    logic [ADDR_W-1:0]   r_k,     n_k;
    logic [ADDR_W-1:0]   r_top,   n_top;
    logic [TOK_W-1:0]    r_tok,   n_tok;

    t_ruler              w_ent;
    logic                w_gt;
    logic                w_lt;
    logic                w_eq;
    logic                w_full;

    // Entry zero is never written and always reads as a confirmed ruler at column zero
    assign w_ent  = (r_k == '0) ? '0 : i_rd_data;

    // Shared column compare unit
    assign w_gt   = r_req.column > w_ent.column;
    assign w_lt   = r_req.column < w_ent.column;
    assign w_eq   = r_req.column == w_ent.column;

    assign w_full = r_top >= ADDR_W'(MAX_TOP);

    // Sequence one request
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_k       = r_k;
        n_top     = r_top;
        n_tok     = r_tok;
        o_wr_en   = 1'b0;
        o_wr_addr = r_top;
        o_wr_data = '0;
        o_rd_en   = 1'b0;
        o_rd_addr = r_top;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_k     = r_top;
                    n_tok   = TOK_NONE;
                    o_rd_en = 1'b1;
                    // Skip the search on error recovery or a begin on a full stack
                    if (i_in_data.recovering || (i_in_data.begin_allowed && w_full)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_EXAM;
                    end
                end
            end
            S_EXAM: begin
                if (r_req.begin_allowed) begin
                    if ((r_k != '0) && w_ent.pending) begin
                        // Step down past a tentative ruler
                        n_k       = r_k - ADDR_W'(1);
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_k - ADDR_W'(1);
                    end else begin
                        if (w_gt) begin
                            o_wr_en           = 1'b1;
                            o_wr_addr         = r_top + ADDR_W'(1);
                            o_wr_data.pending = !r_req.after_newline;
                            o_wr_data.column  = r_req.column;
                            n_top             = r_top + ADDR_W'(1);
                            n_tok             = TOK_BEGIN;
                        end
                        n_state = S_DONE;
                    end
                end else begin
                    priority if (r_req.end_allowed && (w_lt || r_req.stop_token)) begin
                        // Pop; the freed entry is rewritten before any later read
                        if (r_top != '0) begin
                            n_top = r_top - ADDR_W'(1);
                            n_tok = TOK_END;
                        end
                    end else begin
                        // Confirm the top ruler on a line break
                        if (r_req.after_newline && (r_top != '0)) begin
                            o_wr_en           = 1'b1;
                            o_wr_data.pending = 1'b0;
                            o_wr_data.column  = w_ent.column;
                        end
                        if (r_req.separator_allowed && w_eq) begin
                            n_tok = TOK_SEPARATOR;
                        end
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
        end
    end

    // Request and search registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_k   <= n_k;
        r_tok <= n_tok;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_sts.done  = (r_state == S_DONE);
    assign o_sts.token = r_tok;
    assign o_top       = r_top;

endmodule

`default_nettype wire

@@ design/layout_ruler_stack.sv @@
// Top level of the offside-rule layout scanner: sequencer, ruler memory, output register.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------
//   request | in        | i_in_valid / o_in_ready  | i_in_data  (t_req)
//   result  | out       | o_out_valid / i_out_ready| o_out_data (t_rsp)
//
// An item passes through the exam and done states, with one more exam step for each tentative
// ruler that a begin search walks past; the search reads the ruler memory
// one entry per cycle through its single read port.
// Error recovery or a begin on a full stack skips the exam state.
// Reset is synchronous, active low; no clearing pass, entries above the top are never read.
// A waiting result sits in the output register; the next item is taken meanwhile
// and its result holds in the sequencer until the register frees.
`default_nettype none
`include "layout_ruler_stack_defines.svh"

module layout_ruler_stack import lrs_pkg::*; #(
    parameter int MAX_TOP = 255
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out_data
);

    localparam int ADDR_W = $clog2(MAX_TOP + 1);
    localparam int DEPTH  = MAX_TOP + 1;

    t_ctl_sts          w_sts;
    logic [ADDR_W-1:0] w_top;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    t_ruler            w_wr_data;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    t_ruler            w_rd_data;
    logic              w_free;
    logic              w_load;

    logic              r_out_valid, n_out_valid;
    t_rsp              r_out;

    lrs_ctrl #(
        .MAX_TOP (MAX_TOP),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_take     (w_free),
        .o_sts      (w_sts),
        .o_top      (w_top),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data)
    );

    lrs_ruler_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Load the output register when it is empty or being drained
    assign w_free = !r_out_valid || i_out_ready;
    assign w_load = w_sts.done && w_free;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the result payload; depth shows the low bits of the stack top
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.token <= w_sts.token;
            r_out.depth <= DEPTH_W'(w_top);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An accepted item keeps the block busy for the next cycle
    `LRS_ASSERT_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    // The stack top only moves while an item is at work
    `LRS_ASSERT_NXT(a_top_stable_idle, o_in_ready && !i_in_valid, $stable(w_top))
    // A begin result leaves a nonempty stack
    `LRS_ASSERT_IMP(a_begin_nonempty, w_load && (w_sts.token == TOK_BEGIN), w_top != '0)

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the layout ruler stack: directed and random token scans.
`timescale 1ns / 1ps

module testbench;
    import lrs_pkg::*;

    localparam int MAX_TOP    = 255;
    localparam int HOLD_LEN   = 400;
    localparam int PHASE_LEN  = 270;
    localparam int LIMIT      = 2_000_000;
    localparam int DRAIN_WAIT = 20;

    // Scoreboard: mirrors the ruler stack and holds the expected results
    class layout_scoreboard;
        logic [COL_W-1:0] ruler_col [0:MAX_TOP];
        bit               ruler_tentative [0:MAX_TOP];
        int unsigned      top_idx;
        t_rsp             expected_q [$];
        int unsigned      errors;

        function new();
            foreach (ruler_col[i]) begin
                ruler_col[i] = '0;
                ruler_tentative[i] = 1'b0;
            end
            top_idx = 0;
            errors = 0;
        endfunction

        // Work out the layout token and the new depth for one scan
        function t_rsp scan_token(t_req r);
            t_rsp             rsp;
            logic [TOK_W-1:0] tok;
            logic [COL_W-1:0] ruler;
            int               k;
            tok = TOK_NONE;
            if (!r.recovering) begin
                if (r.begin_allowed) begin
                    if (top_idx < MAX_TOP) begin
                        k = top_idx;
                        while (k > 0 && ruler_tentative[k])
                            k--;
                        if (r.column > ruler_col[k]) begin
                            top_idx++;
                            ruler_col[top_idx] = r.column;
                            ruler_tentative[top_idx] = !r.after_newline;
                            tok = TOK_BEGIN;
                        end
                    end
                end else begin
                    if (r.after_newline)
                        ruler_tentative[top_idx] = 1'b0;
                    ruler = ruler_col[top_idx];
                    if (r.end_allowed && (r.column < ruler || r.stop_token)) begin
                        if (top_idx > 0) begin
                            ruler_col[top_idx] = '0;
                            ruler_tentative[top_idx] = 1'b0;
                            top_idx--;
                            tok = TOK_END;
                        end
                    end else if (r.separator_allowed && r.column == ruler) begin
                        tok = TOK_SEPARATOR;
                    end
                end
            end
            rsp.token = tok;
            rsp.depth = top_idx[DEPTH_W-1:0];
            return rsp;
        endfunction

        function void note_request(t_req r);
            expected_q.push_back(scan_token(r));
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: token=%0d depth=%0d", got.token, got.depth);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.token !== want.token) begin
                $error("token: expected %0d, actual %0d", want.token, got.token);
                errors++;
            end
            if (got.depth !== want.depth) begin
                $error("depth: expected %0d, actual %0d", want.depth, got.depth);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_req i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_rsp o_out_data;

    layout_scoreboard sb;
    int  idle_pct;
    int  stall_pct;
    bit  hold_armed;
    int  hold_count;
    int  cycle_count;

    layout_ruler_stack #(.MAX_TOP(MAX_TOP)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Take results; stall at random, hold off once for a long stretch
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_data);
        if (hold_armed && hold_count < HOLD_LEN) begin
            i_out_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic t_req mk_req(bit err, bit beg, bit sep, bit endok, bit lb,
                                    logic [COL_W-1:0] col, bit stop);
        t_req r;
        r.recovering        = err;
        r.begin_allowed     = beg;
        r.separator_allowed = sep;
        r.end_allowed       = endok;
        r.after_newline     = lb;
        r.column            = col;
        r.stop_token        = stop;
        return r;
    endfunction

    // Offer one item after a random gap and wait until it is taken
    task automatic send_request(input t_req r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_request(r);
    endtask

    // Pop every ruler with closing brackets
    task automatic unwind_stack();
        while (sb.top_idx > 0)
            send_request(mk_req(0, 0, 1'($urandom_range(1)), 1, 1'($urandom_range(1)),
                                16'($urandom_range(65535)), 1));
    endtask

    // Build a scan near the current rulers: mostly nesting, dedents and
    // separators, with some raw noise
    function automatic t_req random_scan();
        t_req             r;
        int               pick;
        int               k;
        logic [COL_W-1:0] top_col;
        logic [COL_W-1:0] base_col;
        top_col = sb.ruler_col[sb.top_idx];
        k = sb.top_idx;
        while (k > 0 && sb.ruler_tentative[k])
            k--;
        base_col = sb.ruler_col[k];
        pick = $urandom_range(99);
        r.recovering        = ($urandom_range(15) == 0);
        r.after_newline     = 1'($urandom_range(1));
        r.stop_token        = ($urandom_range(6) == 0);
        r.separator_allowed = ($urandom_range(3) != 0);
        r.end_allowed       = ($urandom_range(3) != 0);
        r.begin_allowed     = (pick < 45);
        if (pick >= 92) begin
            r.recovering        = 1'($urandom_range(1));
            r.begin_allowed     = 1'($urandom_range(1));
            r.separator_allowed = 1'($urandom_range(1));
            r.end_allowed       = 1'($urandom_range(1));
            r.stop_token        = 1'($urandom_range(1));
            r.column            = 16'($urandom_range(65535));
        end else if (r.begin_allowed) begin
            case ($urandom_range(9))
                0:       r.column = base_col;
                1:       r.column = base_col - 16'd1;
                2, 3:    r.column = 16'($urandom_range(65535));
                default: r.column = base_col + 16'($urandom_range(1, 6));
            endcase
        end else begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5: r.column = top_col;
                6, 7, 8, 9:       r.column = top_col - 16'd1;
                10, 11, 12:       r.column = top_col + 16'd1;
                13, 14, 15, 16:   r.column = 16'($urandom_range(top_col));
                default:          r.column = 16'($urandom_range(65535));
            endcase
        end
        return r;
    endfunction

    initial begin
        t_req directed [$];
        int   send_idle [4];
        int   recv_stall [4];
        send_idle  = '{0, 70, 0, 15};
        recv_stall = '{0, 0, 70, 15};

        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_armed = 1'b0;
        hold_count = 0;
        cycle_count = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed scans: recovery, failed and successful begins, search
        // past tentative rulers, separators, dedent and bracket ends,
        // end on an empty stack, extreme columns
        directed.push_back(mk_req(1, 1, 1, 1, 1, 16'hFFFF, 1));
        directed.push_back(mk_req(0, 1, 0, 0, 0, 16'h0000, 0));
        directed.push_back(mk_req(0, 1, 0, 0, 0, 16'd4, 0));
        directed.push_back(mk_req(0, 1, 0, 0, 0, 16'd2, 0));
        directed.push_back(mk_req(0, 0, 1, 0, 1, 16'd2, 0));
        directed.push_back(mk_req(0, 0, 1, 0, 0, 16'd3, 0));
        directed.push_back(mk_req(0, 1, 0, 0, 0, 16'd2, 0));
        directed.push_back(mk_req(0, 1, 0, 0, 1, 16'hFFFF, 0));
        directed.push_back(mk_req(0, 0, 1, 1, 0, 16'hFFFF, 0));
        directed.push_back(mk_req(0, 0, 1, 1, 0, 16'hFFFF, 1));
        directed.push_back(mk_req(0, 0, 0, 1, 0, 16'd1, 0));
        directed.push_back(mk_req(0, 0, 1, 1, 0, 16'd4, 0));
        directed.push_back(mk_req(0, 0, 0, 1, 0, 16'd0, 0));
        directed.push_back(mk_req(0, 0, 1, 1, 0, 16'd0, 1));
        directed.push_back(mk_req(0, 0, 1, 0, 0, 16'd0, 0));
        directed.push_back(mk_req(0, 0, 0, 0, 1, 16'h5555, 0));
        directed.push_back(mk_req(0, 1, 1, 1, 1, 16'hAAAA, 1));
        directed.push_back(mk_req(1, 0, 0, 1, 0, 16'h0000, 1));
        directed.push_back(mk_req(0, 0, 1, 1, 1, 16'h0000, 0));
        foreach (directed[i])
            send_request(directed[i]);

        // Random phases with varying idle and stall pressure
        for (int p = 0; p < 4; p++) begin
            idle_pct = send_idle[p];
            stall_pct = recv_stall[p];
            if (p == 0) begin
                // Hold the output while the sender keeps offering items
                hold_armed <= 1'b1;
                unwind_stack();
                // Nest up to a full stack, try more begins, then unwind
                while (sb.top_idx < MAX_TOP)
                    send_request(mk_req(0, 1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                                        1'($urandom_range(1)),
                                        sb.ruler_col[sb.top_idx] +
                                        16'($urandom_range(1, 2)), 0));
                repeat (3)
                    send_request(mk_req(0, 1, 0, 0, 1, 16'hFFFF, 0));
                send_request(mk_req(0, 0, 1, 1, 0, sb.ruler_col[sb.top_idx], 0));
                unwind_stack();
            end
            repeat (PHASE_LEN)
                send_request(random_scan());
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results
        idle_pct = 0;
        stall_pct = 0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/lrs_pkg.sv
design/lrs_ruler_mem.sv
design/lrs_ctrl.sv
design/layout_ruler_stack.sv
sim/testbench.sv
